/* rtl/mbrt_pkg.sv */
// ---------------------------------------------------------------------------
// Modbus RTU read transaction: shared package
// Types, codes, sizes and the CRC-16 byte update used by the control and
// data path modules.
// ---------------------------------------------------------------------------
package mbrt_pkg;

    // Sizes of the response buffer.
    localparam int MAX_WORDS = 8;
    localparam int MAX_BYTES = 32;
    localparam int WIDX_W    = $clog2(MAX_WORDS);
    localparam int LEN_W     = $clog2(MAX_BYTES + 1);
    localparam int CNT_W     = 4;
    localparam int MIN_FRAME = 5;

    // CRC-16 constants, reflected form.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Exception flag in the returned function byte.
    localparam logic [7:0] EXC_MASK = 8'h80;

    // Request frame layout: six header bytes, then CRC low and high.
    localparam logic [2:0] REQ_HDR_LAST  = 3'd5;
    localparam logic [2:0] REQ_FRM_LAST  = 3'd7;
    localparam logic [2:0] REQ_SLAVE     = 3'd0;
    localparam logic [2:0] REQ_FUNC      = 3'd1;
    localparam logic [2:0] REQ_ADDR_HI   = 3'd2;
    localparam logic [2:0] REQ_ADDR_LO   = 3'd3;
    localparam logic [2:0] REQ_CNT_HI    = 3'd4;
    localparam logic [2:0] REQ_CNT_LO    = 3'd5;
    localparam logic [2:0] REQ_CRC_LO    = 3'd6;
    localparam logic [2:0] REQ_CRC_HI    = 3'd7;

    // Header positions of a received frame.
    localparam logic [LEN_W-1:0] RX_POS_SLAVE = LEN_W'(0);
    localparam logic [LEN_W-1:0] RX_POS_FUNC  = LEN_W'(1);
    localparam logic [LEN_W-1:0] RX_POS_BC    = LEN_W'(2);
    localparam logic [LEN_W-1:0] RX_POS_DATA  = LEN_W'(3);

    // Input item kinds.
    typedef enum logic [1:0] {
        K_REQ  = 2'd0,
        K_BYTE = 2'd1,
        K_END  = 2'd2
    } t_in_kind;

    // Result item kinds.
    typedef enum logic [1:0] {
        O_TX     = 2'd0,
        O_WORD   = 2'd1,
        O_STATUS = 2'd2
    } t_out_kind;

    // Transaction status codes.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SILENCE = 3'd1,
        ST_CRC     = 3'd2,
        ST_EXCEPT  = 3'd3,
        ST_FORMAT  = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TX_CRC,
        S_TX_SEND,
        S_ST_SEND,
        S_WORD_SEND
    } t_state;

    // Commands from the controller to the data path.
    typedef struct packed {
        logic             take_req;
        logic             take_byte;
        logic             take_end;
        logic             crc_step;
        logic             load_tx;
        logic             load_status;
        logic             load_word;
        logic [2:0]       idx;
    } t_cmd;

    // Status from the data path to the controller.
    typedef struct packed {
        logic             out_free;
        logic [CNT_W-1:0] word_cnt;
    } t_stat;

    // One byte through the CRC-16 shift register, LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

/* rtl/mbrt_if.sv */
// ---------------------------------------------------------------------------
// Modbus RTU read transaction: channel interfaces
// Valid/ready channels for input items and for result items.
// ---------------------------------------------------------------------------

// Input item channel.
interface mbrt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic [3:0]  reg_count;
    logic [7:0]  rx_byte;

    modport source (output valid, kind, slave_addr, reg_addr, reg_count, rx_byte,
                    input ready);
    modport sink   (input valid, kind, slave_addr, reg_addr, reg_count, rx_byte,
                    output ready);
endinterface

// Result item channel.
interface mbrt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_word;
    logic [2:0]  word_index;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, out_kind, tx_byte, reg_word, word_index, status, last,
                    input ready);
    modport sink   (input valid, out_kind, tx_byte, reg_word, word_index, status, last,
                    output ready);
endinterface

/* rtl/mbrt_ctrl.sv */
// ---------------------------------------------------------------------------
// Modbus RTU read transaction: controller
// Sequences request CRC, frame transmission, status and word delivery.
// ---------------------------------------------------------------------------
module mbrt_ctrl
    import mbrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_kind,
    output logic       o_in_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       word_last;

    // The word being sent is the final one of the response.
    assign word_last = ({1'b0, r_cnt} + CNT_W'(1)) == i_stat.word_cnt;

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.idx  = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_cnt      = '0;
                if (i_in_valid) begin
                    case (i_in_kind)
                        K_REQ: begin
                            o_cmd.take_req = 1'b1;
                            n_state        = S_TX_CRC;
                        end
                        K_BYTE: begin
                            o_cmd.take_byte = 1'b1;
                        end
                        K_END: begin
                            o_cmd.take_end = 1'b1;
                            n_state        = S_ST_SEND;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_TX_CRC: begin
                o_cmd.crc_step = 1'b1;
                if (r_cnt == REQ_HDR_LAST) begin
                    n_state = S_TX_SEND;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_TX_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.load_tx = 1'b1;
                    if (r_cnt == REQ_FRM_LAST) begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            S_ST_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.load_status = 1'b1;
                    n_cnt             = '0;
                    n_state           = (i_stat.word_cnt == '0) ? S_IDLE : S_WORD_SEND;
                end
            end
            S_WORD_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.load_word = 1'b1;
                    if (word_last) begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // A request always starts the CRC pass.
    a_req_to_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_in_kind == K_REQ) |=> r_state == S_TX_CRC)
        else $error("request did not start the CRC pass");

    // At most one result is loaded per cycle.
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_tx, o_cmd.load_status, o_cmd.load_word}))
        else $error("more than one result load in a cycle");

    // The CRC pass covers the six header bytes only.
    a_crc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TX_CRC |-> r_cnt <= REQ_HDR_LAST)
        else $error("CRC pass ran past the header");

endmodule

/* rtl/mbrt_dp.sv */
// ---------------------------------------------------------------------------
// Modbus RTU read transaction: data path
// Request bytes and CRC, receive buffer and CRC, status check, word store
// and the result output register.
// ---------------------------------------------------------------------------
module mbrt_dp
    import mbrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [7:0]  i_slave_addr,
    input  logic [15:0] i_reg_addr,
    input  logic [3:0]  i_reg_count,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_tx_byte,
    output logic [15:0] o_reg_word,
    output logic [2:0]  o_word_index,
    output logic [2:0]  o_status,
    output logic        o_last
);

    // Configuration and expectations.
    logic [7:0]        r_func_code;
    logic [7:0]        r_exp_slave;
    logic [CNT_W-1:0]  r_exp_cnt;
    logic [15:0]       r_req_addr;
    logic [15:0]       r_tx_crc;

    // Receive side.
    logic [15:0]       r_rx_crc;
    logic [7:0]        r_tail0, r_tail1;
    logic [LEN_W-1:0]  r_rx_len;
    logic [7:0]        r_resp_slave, r_resp_func, r_resp_bc;
    logic [15:0]       r_words [MAX_WORDS];

    // Frame-end results.
    t_status           r_status, n_status;
    logic [CNT_W-1:0]  r_word_cnt;

    // Output register.
    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic [7:0]        r_tx_byte;
    logic [15:0]       r_reg_word;
    logic [2:0]        r_word_idx;
    logic [2:0]        r_out_status;
    logic              r_last;

    logic [7:0]        req_byte;
    logic [LEN_W-1:0]  data_off;
    logic [LEN_W-2:0]  word_sel;
    logic              any_load;

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.word_cnt = r_word_cnt;
    assign any_load = i_cmd.load_tx || i_cmd.load_status || i_cmd.load_word;

    // Byte of the request frame at the current position.
    always_comb begin
        case (i_cmd.idx)
            REQ_SLAVE:   req_byte = r_exp_slave;
            REQ_FUNC:    req_byte = r_func_code;
            REQ_ADDR_HI: req_byte = r_req_addr[15:8];
            REQ_ADDR_LO: req_byte = r_req_addr[7:0];
            REQ_CNT_HI:  req_byte = 8'h00;
            REQ_CNT_LO:  req_byte = {{(8 - CNT_W){1'b0}}, r_exp_cnt};
            REQ_CRC_LO:  req_byte = r_tx_crc[7:0];
            REQ_CRC_HI:  req_byte = r_tx_crc[15:8];
            default:     req_byte = 8'h00;
        endcase
    end

    // Word slot addressed by the current received data byte.
    assign data_off = r_rx_len - RX_POS_DATA;
    assign word_sel = data_off[LEN_W-1:1];

    // Status of the received frame, checks in priority order.
    always_comb begin
        if (r_rx_len < LEN_W'(MIN_FRAME)) begin
            n_status = ST_SILENCE;
        end else if (r_tail0 != r_rx_crc[7:0] || r_tail1 != r_rx_crc[15:8]) begin
            n_status = ST_CRC;
        end else if (r_resp_slave != r_exp_slave) begin
            n_status = ST_CRC;
        end else if ((r_resp_func & EXC_MASK) != 8'h00) begin
            n_status = ST_EXCEPT;
        end else if (r_resp_func != r_func_code
                     || r_exp_cnt > CNT_W'(MAX_WORDS)
                     || r_resp_bc != {3'b000, r_exp_cnt, 1'b0}
                     || r_rx_len != (LEN_W'(MIN_FRAME) + {1'b0, r_exp_cnt, 1'b0})) begin
            n_status = ST_FORMAT;
        end else begin
            n_status = ST_OK;
        end
    end

    // Configuration, expectations and request CRC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func_code <= 8'd3;
            r_exp_slave <= '0;
            r_exp_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_func_code <= i_cfg_wdata;
            end
            if (i_cmd.take_req) begin
                r_exp_slave <= i_slave_addr;
                r_exp_cnt   <= i_reg_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_req_addr <= i_reg_addr;
            r_tx_crc   <= CRC_INIT;
        end else if (i_cmd.crc_step) begin
            r_tx_crc   <= crc_feed(r_tx_crc, req_byte);
        end
    end

    // Receive side: CRC two bytes behind, header capture, length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.take_req || i_cmd.take_end) begin
            r_rx_crc     <= CRC_INIT;
            r_tail0      <= '0;
            r_tail1      <= '0;
            r_rx_len     <= '0;
            r_resp_slave <= '0;
            r_resp_func  <= '0;
            r_resp_bc    <= '0;
        end else if (i_cmd.take_byte && r_rx_len < LEN_W'(MAX_BYTES)) begin
            if (r_rx_len >= RX_POS_BC) begin
                r_rx_crc <= crc_feed(r_rx_crc, r_tail0);
            end
            r_tail0  <= r_tail1;
            r_tail1  <= i_rx_byte;
            r_rx_len <= r_rx_len + LEN_W'(1);
            case (r_rx_len)
                RX_POS_SLAVE: r_resp_slave <= i_rx_byte;
                RX_POS_FUNC:  r_resp_func  <= i_rx_byte;
                RX_POS_BC:    r_resp_bc    <= i_rx_byte;
                default:      r_resp_bc    <= r_resp_bc;
            endcase
        end
    end

    // Word store: high byte first on the wire.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && r_rx_len < LEN_W'(MAX_BYTES) && r_rx_len >= RX_POS_DATA
            && word_sel < (LEN_W - 1)'(MAX_WORDS)) begin
            if (!data_off[0]) begin
                r_words[word_sel[WIDX_W-1:0]][15:8] <= i_rx_byte;
            end else begin
                r_words[word_sel[WIDX_W-1:0]][7:0]  <= i_rx_byte;
            end
        end
    end

    // Frame-end status and number of words to deliver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= ST_OK;
            r_word_cnt <= '0;
        end else if (i_cmd.take_end) begin
            r_status   <= n_status;
            r_word_cnt <= (n_status == ST_OK) ? r_exp_cnt : '0;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (any_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tx) begin
            r_out_kind   <= O_TX;
            r_tx_byte    <= req_byte;
            r_reg_word   <= '0;
            r_word_idx   <= '0;
            r_out_status <= ST_OK;
            r_last       <= (i_cmd.idx == REQ_FRM_LAST);
        end else if (i_cmd.load_status) begin
            r_out_kind   <= O_STATUS;
            r_tx_byte    <= '0;
            r_reg_word   <= '0;
            r_word_idx   <= '0;
            r_out_status <= r_status;
            r_last       <= (r_word_cnt == '0);
        end else if (i_cmd.load_word) begin
            r_out_kind   <= O_WORD;
            r_tx_byte    <= '0;
            r_reg_word   <= r_words[i_cmd.idx[WIDX_W-1:0]];
            r_word_idx   <= i_cmd.idx;
            r_out_status <= ST_OK;
            r_last       <= ({1'b0, i_cmd.idx} + CNT_W'(1)) == r_word_cnt;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_tx_byte    = r_tx_byte;
    assign o_reg_word   = r_reg_word;
    assign o_word_index = r_word_idx;
    assign o_status     = r_out_status;
    assign o_last       = r_last;

    // The receive length saturates at the buffer size.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_len <= LEN_W'(MAX_BYTES))
        else $error("receive length beyond buffer");

    // A result appears only after the controller loaded one.
    a_load_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(any_load))
        else $error("result valid without a load");

    // Words are delivered only for an ok status.
    a_words_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_word |-> (r_status == ST_OK && r_word_cnt != '0))
        else $error("word delivered without ok status");

endmodule

/* rtl/modbus_rtu_read_transaction_unit.sv */
// ---------------------------------------------------------------------------
// Modbus RTU read transaction unit
// Read-registers master: builds the request frame with its CRC-16, checks
// the response and delivers status and register words.
//
//   Channel   Dir   Handshake        Beat contents
//   i_in      in    valid/ready      kind, slave, start, count, rx byte
//   o_out     out   valid/ready      kind, tx byte, word, index, status, last
//   i_cfg_*   in    write enable     function code
//
// A request is taken, then its six header bytes pass one byte per cycle
// through the CRC update and eight result beats follow. A frame end is
// taken, then one status beat and up to eight word beats follow. Every
// result beat passes through the output register; a stall on o_out holds
// the sequence where it is. Input is taken only while no item is in
// progress. Reset is synchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
module modbus_rtu_read_transaction_unit
    import mbrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    mbrt_in_if.sink    i_in,
    mbrt_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    // Controller.
    mbrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Data path.
    mbrt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_slave_addr (i_in.slave_addr),
        .i_reg_addr   (i_in.reg_addr),
        .i_reg_count  (i_in.reg_count),
        .i_rx_byte    (i_in.rx_byte),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_kind   (o_out.out_kind),
        .o_tx_byte    (o_out.tx_byte),
        .o_reg_word   (o_out.reg_word),
        .o_word_index (o_out.word_index),
        .o_status     (o_out.status),
        .o_last       (o_out.last)
    );

endmodule

/* bench/mbrt_checker.sv */
// ---------------------------------------------------------------------------
// Modbus RTU read transaction: result checker
// Watches the input, output and configuration ports of the transaction unit.
// It keeps its own model of the request builder and of the response checker,
// queues the beats that each accepted input item should cause, and compares
// every accepted output beat, field by field, with the oldest one queued.
// ---------------------------------------------------------------------------
module mbrt_checker
    import mbrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    mbrt_in_if         i_in_ch,
    mbrt_out_if        i_out_ch,
    output int         o_fail_count,
    output int         o_pending
);

    // One output beat as the block should deliver it.
    typedef struct {
        t_out_kind   kind;
        logic [7:0]  tx_byte;
        logic [15:0] reg_word;
        logic [2:0]  word_index;
        t_status     status;
        logic        last;
    } t_result;

    t_result     expected_q[$];
    int          fail_count = 0;

    // Model of the block: configuration, receive side and armed expectations.
    logic [7:0]  func_code;
    logic [15:0] rx_crc;
    logic [7:0]  tail_old;
    logic [7:0]  tail_new;
    int          rx_len;
    logic [7:0]  hdr_slave;
    logic [7:0]  hdr_func;
    logic [7:0]  hdr_bc;
    logic [15:0] words [MAX_WORDS];
    logic [7:0]  want_slave;
    logic [3:0]  want_count;

    // CRC-16 update by one byte, reflected form, least significant bit first.
    function automatic logic [15:0] crc_after_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        repeat (8) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    function automatic t_result make_result(input t_out_kind k, input logic [7:0] tx,
                                            input logic [15:0] w, input logic [2:0] idx,
                                            input t_status st, input logic lst);
        t_result r;
        r.kind       = k;
        r.tx_byte    = tx;
        r.reg_word   = w;
        r.word_index = idx;
        r.status     = st;
        r.last       = lst;
        return r;
    endfunction

    // The receive side starts afresh after a request and after a frame end.
    task automatic clear_receiver();
        rx_crc    = CRC_INIT;
        tail_old  = 8'h00;
        tail_new  = 8'h00;
        rx_len    = 0;
        hdr_slave = 8'h00;
        hdr_func  = 8'h00;
        hdr_bc    = 8'h00;
    endtask

    task automatic reset_model();
        func_code  = 8'd3;
        want_slave = 8'h00;
        want_count = 4'd0;
        clear_receiver();
        foreach (words[i]) words[i] = 16'h0000;
    endtask

    // A request gives the eight frame bytes and arms the response check.
    task automatic predict_request(input logic [7:0] slave, input logic [15:0] regad,
                                   input logic [3:0] cnt);
        logic [7:0]  frm [8];
        logic [15:0] c;
        frm[0] = slave;
        frm[1] = func_code;
        frm[2] = regad[15:8];
        frm[3] = regad[7:0];
        frm[4] = 8'h00;
        frm[5] = {4'h0, cnt};
        c = CRC_INIT;
        for (int k = 0; k < 6; k++) c = crc_after_byte(c, frm[k]);
        frm[6] = c[7:0];
        frm[7] = c[15:8];
        for (int k = 0; k < 8; k++) begin
            expected_q.push_back(make_result(O_TX, frm[k], 16'h0000, 3'd0, ST_OK, k == 7));
        end
        want_slave = slave;
        want_count = cnt;
        clear_receiver();
    endtask

    // A received byte is buffered; the CRC trails the line by two bytes.
    task automatic predict_byte(input logic [7:0] b);
        int off;
        int w;
        if (rx_len >= MAX_BYTES) return;
        if (rx_len >= 2) rx_crc = crc_after_byte(rx_crc, tail_old);
        tail_old = tail_new;
        tail_new = b;
        case (rx_len)
            0: hdr_slave = b;
            1: hdr_func  = b;
            2: hdr_bc    = b;
            default: begin
                off = rx_len - 3;
                w   = off >> 1;
                if (w < MAX_WORDS) begin
                    if (off % 2 == 0) words[w][15:8] = b;
                    else              words[w][7:0]  = b;
                end
            end
        endcase
        rx_len++;
    endtask

    // A frame end gives the status and, when it is good, the words.
    task automatic predict_end();
        t_status st;
        int      cnt;
        cnt = int'(want_count);
        if (rx_len < MIN_FRAME) begin
            st = ST_SILENCE;
        end else if (tail_old != rx_crc[7:0] || tail_new != rx_crc[15:8]) begin
            st = ST_CRC;
        end else if (hdr_slave != want_slave) begin
            st = ST_CRC;
        end else if ((hdr_func & EXC_MASK) != 8'h00) begin
            st = ST_EXCEPT;
        end else if (hdr_func != func_code || cnt > MAX_WORDS || hdr_bc != 2 * cnt ||
                     rx_len != MIN_FRAME + 2 * cnt) begin
            st = ST_FORMAT;
        end else begin
            st = ST_OK;
        end
        if (st != ST_OK) cnt = 0;
        expected_q.push_back(make_result(O_STATUS, 8'h00, 16'h0000, 3'd0, st, cnt == 0));
        for (int k = 0; k < cnt; k++) begin
            expected_q.push_back(make_result(O_WORD, 8'h00, words[k], 3'(k), ST_OK,
                                             k + 1 == cnt));
        end
        clear_receiver();
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("[%0t] mismatch: %s (got %0h, want %0h)", $time, what, got, want);
    endtask

    // Compare one accepted output beat with the oldest expectation.
    task automatic check_beat();
        t_result want;
        if (expected_q.size() == 0) begin
            report_mismatch("output beat with none expected, kind",
                            int'(i_out_ch.out_kind), 0);
            return;
        end
        want = expected_q.pop_front();
        if (i_out_ch.out_kind !== want.kind)
            report_mismatch("out_kind", int'(i_out_ch.out_kind), int'(want.kind));
        if (i_out_ch.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", int'(i_out_ch.tx_byte), int'(want.tx_byte));
        if (i_out_ch.reg_word !== want.reg_word)
            report_mismatch("reg_word", int'(i_out_ch.reg_word), int'(want.reg_word));
        if (i_out_ch.word_index !== want.word_index)
            report_mismatch("word_index", int'(i_out_ch.word_index), int'(want.word_index));
        if (i_out_ch.status !== want.status)
            report_mismatch("status", int'(i_out_ch.status), int'(want.status));
        if (i_out_ch.last !== want.last)
            report_mismatch("last", int'(i_out_ch.last), int'(want.last));
    endtask

    // Sample every port at the rising edge. Output beats are checked before
    // the input beat of the same edge is modelled, since a result never
    // appears in the cycle its item is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            expected_q.delete();
        end else begin
            if (i_cfg_we === 1'b1) func_code = i_cfg_wdata;
            if (i_out_ch.valid === 1'b1 && i_out_ch.ready === 1'b1) check_beat();
            if (i_in_ch.valid === 1'b1 && i_in_ch.ready === 1'b1) begin
                case (i_in_ch.kind)
                    K_REQ:   predict_request(i_in_ch.slave_addr, i_in_ch.reg_addr,
                                             i_in_ch.reg_count);
                    K_BYTE:  predict_byte(i_in_ch.rx_byte);
                    K_END:   predict_end();
                    default: ;
                endcase
            end
        end
        o_pending    = expected_q.size();
        o_fail_count = fail_count;
    end

endmodule

/* bench/tb_top.sv */
// ---------------------------------------------------------------------------
// Modbus RTU read transaction unit: testbench top
// Drives requests, received bytes and frame ends into the unit, paces the
// result side, changes the function code between phases and gives the
// verdict. Prediction and comparison live in the checker beside the unit.
// ---------------------------------------------------------------------------
module tb_top
    import mbrt_pkg::*;
();

    localparam int TARGET_ITEMS  = 500;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int NUM_PHASES    = 6;

    // Input kind that the unit does not know and must ignore.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Shapes of response frame that the generator can build.
    typedef enum int {
        RP_GOOD,
        RP_BAD_CRC,
        RP_BAD_SLAVE,
        RP_EXCEPT,
        RP_BAD_FUNC,
        RP_BAD_BC,
        RP_BAD_LEN,
        RP_SHORT,
        RP_OVERFLOW
    } t_reply;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    mbrt_in_if  in_ch ();
    mbrt_out_if out_ch ();

    int         fail_count;
    int         pending;
    int         items_sent = 0;
    int         cycle_count = 0;
    logic       calm;
    logic       hold_req;
    logic [7:0] cur_fc;
    logic [7:0] last_slave = 8'h00;
    logic [3:0] last_cnt = 4'd0;
    logic [7:0] frame_q[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    modbus_rtu_read_transaction_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    mbrt_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** modbus_rtu_read_transaction_unit: FAILED **");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side pacing, with a long hold-off whenever one is requested.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req     = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    out_ch.ready = 1'b1;
                end else begin
                    out_ch.ready = 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Offer one input beat after a random gap and hold it until taken.
    task automatic push_item(input logic [1:0] kind, input logic [7:0] slave,
                             input logic [15:0] regad, input logic [3:0] cnt,
                             input logic [7:0] rxb);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.kind       = kind;
        in_ch.slave_addr = slave;
        in_ch.reg_addr   = regad;
        in_ch.reg_count  = cnt;
        in_ch.rx_byte    = rxb;
        in_ch.valid      = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic send_request(input logic [7:0] slave, input logic [15:0] regad,
                                input logic [3:0] cnt);
        push_item(K_REQ, slave, regad, cnt, 8'($urandom));
        last_slave = slave;
        last_cnt   = cnt;
        items_sent++;
    endtask

    task automatic send_end();
        push_item(K_END, 8'($urandom), 16'($urandom), 4'($urandom), 8'($urandom));
        items_sent++;
    endtask

    // Send the bytes of frame_q, a stray unknown beat now and then, then the end.
    task automatic send_frame();
        foreach (frame_q[i]) begin
            if ($urandom_range(0, 39) == 0)
                push_item(KIND_UNUSED, 8'($urandom), 16'($urandom), 4'($urandom),
                          8'($urandom));
            push_item(K_BYTE, 8'($urandom), 16'($urandom), 4'($urandom), frame_q[i]);
            if (i < MAX_BYTES) items_sent++;
        end
        send_end();
    endtask

    function automatic logic [15:0] frame_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_q[i]) begin
            c = c ^ {8'h00, frame_q[i]};
            repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Build a response frame of the given shape into frame_q.
    task automatic build_reply(input logic [7:0] slave, input logic [7:0] func,
                               input int cnt, input t_reply shape);
        int          nbytes;
        int          delta;
        int          pos;
        logic [7:0]  bc;
        logic [15:0] c;
        frame_q.delete();
        case (shape)
            RP_SHORT: begin
                repeat ($urandom_range(0, MIN_FRAME - 1)) frame_q.push_back(8'($urandom));
            end
            RP_OVERFLOW: begin
                repeat ($urandom_range(MAX_BYTES + 1, MAX_BYTES + 8))
                    frame_q.push_back(8'($urandom));
            end
            RP_EXCEPT: begin
                frame_q.push_back(slave);
                frame_q.push_back(func | EXC_MASK);
                frame_q.push_back(8'($urandom));
            end
            default: begin
                nbytes = 2 * cnt;
                bc     = 8'(nbytes);
                if (shape == RP_BAD_BC) bc = bc + 8'($urandom_range(1, 255));
                if (shape == RP_BAD_LEN) begin
                    delta = $urandom_range(1, 2);
                    if (nbytes >= delta && $urandom_range(0, 1) == 1) nbytes -= delta;
                    else nbytes += delta;
                end
                frame_q.push_back(shape == RP_BAD_SLAVE ? slave ^ 8'($urandom_range(1, 255))
                                                        : slave);
                frame_q.push_back(shape == RP_BAD_FUNC ? func ^ 8'($urandom_range(1, 255))
                                                       : func);
                frame_q.push_back(bc);
                repeat (nbytes) frame_q.push_back(8'($urandom));
            end
        endcase
        if (shape != RP_SHORT && shape != RP_OVERFLOW) begin
            c = frame_crc();
            frame_q.push_back(c[7:0]);
            frame_q.push_back(c[15:8]);
        end
        if (shape == RP_BAD_CRC) begin
            pos = $urandom_range(0, frame_q.size() - 1);
            frame_q[pos] = frame_q[pos] ^ 8'(1 << $urandom_range(0, 7));
        end
    endtask

    function automatic t_reply pick_reply();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return RP_GOOD;
        if (r < 52) return RP_BAD_CRC;
        if (r < 59) return RP_BAD_SLAVE;
        if (r < 67) return RP_EXCEPT;
        if (r < 74) return RP_BAD_FUNC;
        if (r < 81) return RP_BAD_BC;
        if (r < 88) return RP_BAD_LEN;
        if (r < 94) return RP_SHORT;
        return RP_OVERFLOW;
    endfunction

    // Mostly legal counts, sometimes zero or above the buffer size.
    function automatic logic [3:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 4'd0;
        if (r < 16) return 4'($urandom_range(MAX_WORDS + 1, 15));
        return 4'($urandom_range(1, MAX_WORDS));
    endfunction

    // One random transaction: usually a request and its response, sometimes
    // a response against the kept expectations, sometimes line noise.
    task automatic random_transaction();
        logic [7:0] slave;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 4) hold_req = 1'b1;
        if (r < 88) begin
            slave = 8'($urandom);
            send_request(slave, 16'($urandom), pick_count());
            if ($urandom_range(0, 9) == 0) return;
            build_reply(slave, cur_fc, int'(last_cnt), pick_reply());
        end else if (r < 94) begin
            build_reply(last_slave, cur_fc, int'(last_cnt), pick_reply());
        end else begin
            frame_q.delete();
            repeat ($urandom_range(0, 40)) frame_q.push_back(8'($urandom));
        end
        send_frame();
    endtask

    // Wait until every queued result has come and the unit has settled.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_function_code(input logic [7:0] value);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        cur_fc      = value;
    endtask

    // Main stimulus.
    initial begin
        logic [7:0] fc_plan [NUM_PHASES];
        int         base;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 8'h00;
        in_ch.valid      = 1'b0;
        in_ch.kind       = K_REQ;
        in_ch.slave_addr = 8'h00;
        in_ch.reg_addr   = 16'h0000;
        in_ch.reg_count  = 4'd0;
        in_ch.rx_byte    = 8'h00;
        calm             = 1'b0;
        hold_req         = 1'b0;
        cur_fc           = 8'd3;
        fc_plan          = '{8'd4, 8'h00, 8'hFF, 8'd3, 8'h00, 8'd3};
        fc_plan[4]       = 8'($urandom);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_function_code(8'd3);

        // Directed part: frame end before any request, an unknown kind,
        // a one-word read at the lowest fields, a zero-count read at the
        // highest fields under a long result hold-off, an exception reply
        // against the kept expectations, and a short frame.
        send_end();
        push_item(KIND_UNUSED, 8'hFF, 16'hFFFF, 4'hF, 8'hFF);
        send_request(8'h00, 16'h0000, 4'd1);
        build_reply(8'h00, cur_fc, 1, RP_GOOD);
        send_frame();
        hold_req = 1'b1;
        send_request(8'hFF, 16'hFFFF, 4'd0);
        build_reply(8'hFF, cur_fc, 0, RP_GOOD);
        send_frame();
        build_reply(8'hFF, cur_fc, 0, RP_EXCEPT);
        send_frame();
        build_reply(8'hFF, cur_fc, 0, RP_SHORT);
        send_frame();

        // Random part, in phases with different function codes; one phase
        // runs with no random gaps on either side.
        base = items_sent;
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_function_code(fc_plan[p]);
            calm = (p == 3);
            while (items_sent < base + TARGET_ITEMS * (p + 1) / NUM_PHASES)
                random_transaction();
        end
        calm = 1'b0;

        drain();
        if (fail_count == 0) begin
            $display("** modbus_rtu_read_transaction_unit: PASSED **");
        end else begin
            $display("** modbus_rtu_read_transaction_unit: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mbrt_pkg.sv
rtl/mbrt_if.sv
rtl/mbrt_ctrl.sv
rtl/mbrt_dp.sv
rtl/modbus_rtu_read_transaction_unit.sv
bench/mbrt_checker.sv
bench/tb_top.sv
